FILE: design/char_lcd_nibble_writer_assert.svh
// Assertion macros shared by the LCD writer modules.
// Each expects signals named clk and rst_n in the using module.
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define CLNW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CLNW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/clnw_pkg.sv
package clnw_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_DATA    = 2'd1,
        OP_CURSOR  = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    // LCD command bytes
    localparam logic [7:0] CMD_INIT_A     = 8'h33;
    localparam logic [7:0] CMD_INIT_B     = 8'h32;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] ADDR_ROW0      = 8'h80;
    localparam logic [7:0] ADDR_ROW1      = 8'hC0;
    localparam logic [1:0] ROW_ONE        = 2'd1;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_HIGH = 1'b1;
    localparam logic [15:0] ENABLE_LOW_RESET  = 16'd500;
    localparam logic [15:0] ENABLE_HIGH_RESET = 16'd1500;

    // Job queue depth between decode and sequencer
    localparam int QUEUE_DEPTH = 2;

    // Pin step counter: [1:0] step within a byte, [3:2] byte of init
    localparam logic [3:0] STEP_INIT_FINAL = 4'd15;
    localparam logic [1:0] STEP_BYTE_FINAL = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] col;
    } in_t;

    typedef struct packed {
        logic [3:0]  data_nibble;
        logic        reg_select;
        logic        read_write;
        logic        enable_pin;
        logic [15:0] hold_time;
        logic        last;
    } out_t;

    // One queued job: either a single byte or the whole init sequence
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] byte_value;
    } job_t;

    // Queue status seen by producer and consumer
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Init sequence bytes
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_INIT_A;
            2'd1:    b = CMD_INIT_B;
            2'd2:    b = CMD_FUNC_SET;
            default: b = CMD_DISPLAY_ON;
        endcase
        return b;
    endfunction

endpackage

FILE: design/char_lcd_nibble_writer.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------
// in       | input     | in_valid / in_stall  | clnw_pkg::in_t
// out      | output    | out_valid / out_stall| clnw_pkg::out_t
// cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// One pin step leaves per cycle unless the output stalls; init sends four bytes.
// The step sequencer in clnw_back sets that rate; a job queue of DEPTH
// entries lets requests be accepted while the sequencer is busy.
// Reset is asynchronous, active low; hold times return to 500 and 1500.
// An output stall freezes the sequencer; the input stalls only when the queue is full.
module char_lcd_nibble_writer #(
    parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  clnw_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output clnw_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [clnw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [15:0]          low_time_reg;
    logic [15:0]          high_time_reg;
    logic                 push;
    logic                 pop;
    clnw_pkg::job_t       push_job;
    clnw_pkg::job_t       head_job;
    clnw_pkg::q_status_t  q_status;

    // Hold time registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_time_reg  <= clnw_pkg::ENABLE_LOW_RESET;
            high_time_reg <= clnw_pkg::ENABLE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clnw_pkg::CFG_ENABLE_LOW:  low_time_reg  <= cfg_data;
                clnw_pkg::CFG_ENABLE_HIGH: high_time_reg <= cfg_data;
                default:                   low_time_reg  <= low_time_reg;
            endcase
        end
    end

    clnw_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    clnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .low_time  (low_time_reg),
        .high_time (high_time_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: design/clnw_front.sv
module clnw_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  clnw_pkg::in_t        in_data,
    input  clnw_pkg::q_status_t  q_status,
    output logic                 push,
    output clnw_pkg::job_t       push_job
);

    logic [7:0] cursor_addr;

    // Cursor address: row 1 at 0xC0, every other row at 0x80
    assign cursor_addr = ((in_data.row == clnw_pkg::ROW_ONE) ? clnw_pkg::ADDR_ROW1
                                                             : clnw_pkg::ADDR_ROW0)
                         + {2'b00, in_data.col};

    // Classify the request into one queued job
    always_comb
    begin
        push_job.is_init    = 1'b0;
        push_job.reg_select = 1'b0;
        push_job.byte_value = in_data.byte_value;
        case (in_data.op)
            clnw_pkg::OP_COMMAND:
            begin
                push_job.byte_value = in_data.byte_value;
            end
            clnw_pkg::OP_DATA:
            begin
                push_job.reg_select = 1'b1;
            end
            clnw_pkg::OP_CURSOR:
            begin
                push_job.byte_value = cursor_addr;
            end
            default:
            begin
                push_job.is_init = 1'b1;
            end
        endcase
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

FILE: design/clnw_queue.sv
`include "char_lcd_nibble_writer_assert.svh"

module clnw_queue #(
    parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clnw_pkg::job_t       push_job,
    input  logic                 pop,
    output clnw_pkg::job_t       head_job,
    output clnw_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    clnw_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);

    `CLNW_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_FULL, "queue count beyond depth")
    `CLNW_ASSERT_IMPLY(a_no_overflow, status.full, !push, "push into full queue")

endmodule

FILE: design/clnw_back.sv
`include "char_lcd_nibble_writer_assert.svh"

module clnw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clnw_pkg::job_t       head_job,
    input  clnw_pkg::q_status_t  q_status,
    output logic                 pop,
    input  logic [15:0]          low_time,
    input  logic [15:0]          high_time,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clnw_pkg::out_t       out_data
);

    logic            busy_reg, busy_next;
    logic [3:0]      step_reg, step_next;
    clnw_pkg::job_t  job_reg, job_next;
    logic            out_valid_reg, out_valid_next;
    clnw_pkg::out_t  out_data_reg, out_data_next;

    clnw_pkg::job_t  cur_job;
    logic [3:0]      cur_step;
    logic [7:0]      cur_byte;
    logic            out_free;
    logic            emit;
    logic            final_step;

    // Current job comes straight from the queue head when idle
    assign cur_job  = busy_reg ? job_reg : head_job;
    assign cur_step = busy_reg ? step_reg : '0;
    assign cur_byte = cur_job.is_init ? clnw_pkg::init_byte(cur_step[3:2])
                                      : cur_job.byte_value;

    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = out_free && (busy_reg || !q_status.empty);
    assign pop        = emit && !busy_reg;
    assign final_step = cur_job.is_init ? (cur_step == clnw_pkg::STEP_INIT_FINAL)
                                        : (cur_step[1:0] == clnw_pkg::STEP_BYTE_FINAL);

    // Pin step sequencer and output register
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            busy_next      = !final_step;
            step_next      = final_step ? '0 : cur_step + 1'b1;
            job_next       = cur_job;
            out_valid_next = 1'b1;
            out_data_next.data_nibble = cur_step[1] ? cur_byte[3:0] : cur_byte[7:4];
            out_data_next.reg_select  = cur_job.reg_select;
            out_data_next.read_write  = 1'b0;
            out_data_next.enable_pin  = cur_step[0];
            out_data_next.hold_time   = cur_step[0] ? high_time : low_time;
            out_data_next.last        = final_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CLNW_ASSERT_IMPLY(a_idle_step, !busy_reg, step_reg == 4'd0, "step count not cleared when idle")
    `CLNW_ASSERT_IMPLY(a_byte_step, busy_reg && !job_reg.is_init, step_reg[3:2] == 2'd0,
        "byte job past its fourth step")
    `CLNW_ASSERT_IMPLY(a_pop_empty, pop, !q_status.empty, "pop from empty queue")

endmodule
